@@ rtl/twsg_pkg.sv @@
// ----------------------------------------------------------------------------
// twsg_pkg
// Shared types, codes and default sizes for the toroidal window sum grid.
// ----------------------------------------------------------------------------
package twsg_pkg;

   localparam int MAX_ROWS_DEF    = 64;
   localparam int MAX_COLS_DEF    = 64;
   localparam int MAX_WIN_DEF     = 16;
   localparam int PRIOR_VALUE_DEF = 16;
   localparam int CELL_BITS_DEF   = 24;

   localparam int GRID_REG_W = 7;
   localparam int WIN_REG_W  = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int GRID_ROWS_RST = 64;
   localparam int GRID_COLS_RST = 64;
   localparam int WIN_ROWS_RST  = 4;
   localparam int WIN_COLS_RST  = 4;

   localparam logic [1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [1:0] REG_GRID_COLS = 2'd1;
   localparam logic [1:0] REG_WIN_ROWS  = 2'd2;
   localparam logic [1:0] REG_WIN_COLS  = 2'd3;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef struct packed {
      logic [GRID_REG_W-1:0] grid_rows;
      logic [GRID_REG_W-1:0] grid_cols;
      logic [WIN_REG_W-1:0]  win_rows;
      logic [WIN_REG_W-1:0]  win_cols;
   } cfg_type;

endpackage

@@ rtl/twsg_ram.sv @@
// ----------------------------------------------------------------------------
// twsg_ram
// Generic single-address RAM with registered read data.
// ----------------------------------------------------------------------------
module twsg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/twsg_alu.sv @@
// ----------------------------------------------------------------------------
// twsg_alu
// Shared saturating adder: clamps a + b into [0, limit] and flags clamping.
// ----------------------------------------------------------------------------
module twsg_alu #(
   parameter int W = 34
) (
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   input  logic        [W-1:0] limit,
   output logic        [W-1:0] res,
   output logic                sat
);

   logic signed [W-1:0] sum;

   always_comb begin
      sum = a + b;
      if (sum < 0) begin
         res = '0;
         sat = 1'b1;
      end else if ($unsigned(sum) > limit) begin
         res = limit;
         sat = 1'b1;
      end else begin
         res = $unsigned(sum);
         sat = 1'b0;
      end
   end

endmodule

@@ rtl/twsg_csr.sv @@
// ----------------------------------------------------------------------------
// twsg_csr
// APB-style register file for grid and window dimensions, clamped on write.
// ----------------------------------------------------------------------------
module twsg_csr #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int MAX_WIN  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [twsg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [twsg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [twsg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output twsg_pkg::cfg_type                  cfg
);

   import twsg_pkg::*;

   localparam logic [GRID_REG_W-1:0] ROWS_HI =
      (MAX_ROWS > 127) ? 7'd127 : GRID_REG_W'(MAX_ROWS);
   localparam logic [GRID_REG_W-1:0] COLS_HI =
      (MAX_COLS > 127) ? 7'd127 : GRID_REG_W'(MAX_COLS);
   localparam logic [WIN_REG_W-1:0] WIN_HI =
      (MAX_WIN > 31) ? 5'd31 : WIN_REG_W'(MAX_WIN);

   function automatic logic [GRID_REG_W-1:0] clamp_grid(
      input logic [GRID_REG_W-1:0] v,
      input logic [GRID_REG_W-1:0] hi
   );
      logic [GRID_REG_W-1:0] r;
      if (v == '0) begin
         r = GRID_REG_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [WIN_REG_W-1:0] clamp_win(
      input logic [WIN_REG_W-1:0] v
   );
      logic [WIN_REG_W-1:0] r;
      if (v == '0) begin
         r = WIN_REG_W'(1);
      end else if (v > WIN_HI) begin
         r = WIN_HI;
      end else begin
         r = v;
      end
      return r;
   endfunction

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GRID_ROWS: cfg_in.grid_rows = clamp_grid(pwdata[GRID_REG_W-1:0], ROWS_HI);
            REG_GRID_COLS: cfg_in.grid_cols = clamp_grid(pwdata[GRID_REG_W-1:0], COLS_HI);
            REG_WIN_ROWS:  cfg_in.win_rows  = clamp_win(pwdata[WIN_REG_W-1:0]);
            REG_WIN_COLS:  cfg_in.win_cols  = clamp_win(pwdata[WIN_REG_W-1:0]);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows <= clamp_grid(GRID_REG_W'(GRID_ROWS_RST), ROWS_HI);
         cfg_ff.grid_cols <= clamp_grid(GRID_REG_W'(GRID_COLS_RST), COLS_HI);
         cfg_ff.win_rows  <= clamp_win(WIN_REG_W'(WIN_ROWS_RST));
         cfg_ff.win_cols  <= clamp_win(WIN_REG_W'(WIN_COLS_RST));
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRID_ROWS: prdata = CSR_DATA_W'(cfg_ff.grid_rows);
         REG_GRID_COLS: prdata = CSR_DATA_W'(cfg_ff.grid_cols);
         REG_WIN_ROWS:  prdata = CSR_DATA_W'(cfg_ff.win_rows);
         REG_WIN_COLS:  prdata = CSR_DATA_W'(cfg_ff.win_cols);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/toroidal_window_sum_grid.sv @@
// ----------------------------------------------------------------------------
// toroidal_window_sum_grid
// Grid of Q20.4 counts with cell write, saturating add and wrapped window sum.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a clock edge with start high
//   and busy low; req_mode selects write (0), add delta (1), window query (2).
//   Result channel: every transaction yields one result, shown for one cycle
//   with rsp_valid high. The receiver cannot stall; results never wait.
//   Configuration: APB-style port; grid_rows, grid_cols, win_rows, win_cols
//   at byte addresses 0, 4, 8, 12; write only while idle (not checked).
// Steps per mode; the earliest next accept is the edge ending rsp_valid:
//   unused mode or coordinate out of range: busy stays low
//   write: cell write; add: read, then write back
//   query: one cell read per cycle over the win_rows*win_cols window, from the
//   single-port cell RAM through the shared saturating adder.
// Reset: the RAM is swept to the prior value, one cell a cycle over all
//   MAX_ROWS*MAX_COLS cells (4096 by default) with busy high; configuration
//   writes are taken meanwhile.
// ----------------------------------------------------------------------------
module toroidal_window_sum_grid #(
   parameter int MAX_ROWS    = twsg_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS    = twsg_pkg::MAX_COLS_DEF,
   parameter int MAX_WIN     = twsg_pkg::MAX_WIN_DEF,
   parameter int PRIOR_VALUE = twsg_pkg::PRIOR_VALUE_DEF,
   parameter int CELL_BITS   = twsg_pkg::CELL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_mode,
   input  logic [5:0]                       req_row,
   input  logic [5:0]                       req_col,
   input  logic [23:0]                      req_cell_value,
   input  logic signed [23:0]               req_delta,
   output logic                             rsp_valid,
   output logic [31:0]                      rsp_window_sum,
   output logic [1:0]                       rsp_status,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [twsg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [twsg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [twsg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   import twsg_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ALU_W = ((CELL_BITS > 32) ? CELL_BITS : 32) + 2;
   localparam logic [63:0] CELL_MAX64 = (64'd1 << CELL_BITS) - 64'd1;
   localparam logic [CELL_BITS-1:0] INIT_VALUE =
      (64'(PRIOR_VALUE) > CELL_MAX64) ? {CELL_BITS{1'b1}} : CELL_BITS'(PRIOR_VALUE);
   localparam logic [ALU_W-1:0] CELL_LIMIT = ALU_W'({CELL_BITS{1'b1}});
   localparam logic [ALU_W-1:0] SUM_LIMIT  = ALU_W'(32'hFFFF_FFFF);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_WRITE    = 3'd2;
   localparam logic [2:0] S_ADD_RD   = 3'd3;
   localparam logic [2:0] S_ADD_WR   = 3'd4;
   localparam logic [2:0] S_SUM      = 3'd5;
   localparam logic [2:0] S_SUM_TAIL = 3'd6;

   cfg_type cfg;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_sum_ff, rsp_sum_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [5:0]              row_ff, row_in;
   logic [5:0]              col_ff, col_in;
   logic [23:0]             value_ff, value_in;
   logic signed [23:0]      delta_ff, delta_in;
   logic [GRID_REG_W-1:0]   rr_ff, rr_in;
   logic [GRID_REG_W-1:0]   cc_ff, cc_in;
   logic [WIN_REG_W-1:0]    i_ff, i_in;
   logic [WIN_REG_W-1:0]    j_ff, j_in;
   logic [31:0]             acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic                    pend_ff, pend_in;

   logic                    accept;
   logic                    coord_bad;
   logic [GRID_REG_W-1:0]   row_sel, col_sel;
   logic [GRID_REG_W-1:0]   rr_inc, cc_inc, rr_next, cc_next;
   logic                    last_col, last_row;
   logic [AW-1:0]           cell_addr;
   logic                    ram_we;
   logic [AW-1:0]           ram_addr;
   logic [CELL_BITS-1:0]    ram_wdata, ram_rdata;
   logic signed [ALU_W-1:0] alu_a, alu_b;
   logic [ALU_W-1:0]        alu_limit, alu_res;
   logic                    alu_sat;

   twsg_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .MAX_WIN  (MAX_WIN)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   twsg_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   twsg_alu #(
      .W (ALU_W)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .limit (alu_limit),
      .res   (alu_res),
      .sat   (alu_sat)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   assign coord_bad = ({1'b0, req_row} >= cfg.grid_rows) ||
                      ({1'b0, req_col} >= cfg.grid_cols);

   // window walk with wrap at the grid edges
   assign rr_inc   = rr_ff + GRID_REG_W'(1);
   assign cc_inc   = cc_ff + GRID_REG_W'(1);
   assign rr_next  = (rr_inc >= cfg.grid_rows) ? '0 : rr_inc;
   assign cc_next  = (cc_inc >= cfg.grid_cols) ? '0 : cc_inc;
   assign last_col = (j_ff == cfg.win_cols - WIN_REG_W'(1));
   assign last_row = (i_ff == cfg.win_rows - WIN_REG_W'(1));

   assign row_sel   = (state_ff == S_SUM) ? rr_ff : {1'b0, row_ff};
   assign col_sel   = (state_ff == S_SUM) ? cc_ff : {1'b0, col_ff};
   assign cell_addr = AW'(32'(row_sel) * 32'(MAX_COLS) + 32'(col_sel));

   assign ram_we    = (state_ff == S_CLEAR) || (state_ff == S_WRITE) ||
                      (state_ff == S_ADD_WR);
   assign ram_addr  = (state_ff == S_CLEAR) ? clr_ff : cell_addr;
   assign ram_wdata = (state_ff == S_CLEAR) ? INIT_VALUE : alu_res[CELL_BITS-1:0];

   always_comb begin
      case (state_ff)
         S_WRITE: begin
            alu_a     = ALU_W'(value_ff);
            alu_b     = '0;
            alu_limit = CELL_LIMIT;
         end
         S_ADD_WR: begin
            alu_a     = ALU_W'(ram_rdata);
            alu_b     = {{(ALU_W-24){delta_ff[23]}}, delta_ff};
            alu_limit = CELL_LIMIT;
         end
         default: begin
            alu_a     = ALU_W'(acc_ff);
            alu_b     = ALU_W'(ram_rdata);
            alu_limit = SUM_LIMIT;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      value_in      = value_ff;
      delta_in      = delta_ff;
      rr_in         = rr_ff;
      cc_in         = cc_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      pend_in       = pend_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               row_in   = req_row;
               col_in   = req_col;
               value_in = req_cell_value;
               delta_in = req_delta;
               rr_in    = {1'b0, req_row};
               cc_in    = {1'b0, req_col};
               i_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               ovf_in   = 1'b0;
               pend_in  = 1'b0;
               if (req_mode == MODE_WRITE || req_mode == MODE_ADD ||
                   req_mode == MODE_QUERY) begin
                  if (coord_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_sum_in    = '0;
                     rsp_status_in = ST_RANGE;
                  end else if (req_mode == MODE_WRITE) begin
                     state_in = S_WRITE;
                  end else if (req_mode == MODE_ADD) begin
                     state_in = S_ADD_RD;
                  end else begin
                     state_in = S_SUM;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_sum_in    = '0;
                  rsp_status_in = ST_OK;
               end
            end
         end
         S_WRITE, S_ADD_WR: begin
            rsp_valid_in  = 1'b1;
            rsp_sum_in    = '0;
            rsp_status_in = alu_sat ? ST_SAT : ST_OK;
            state_in      = S_IDLE;
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_SUM: begin
            pend_in = 1'b1;
            if (pend_ff) begin
               acc_in = alu_res[31:0];
               ovf_in = ovf_ff | alu_sat;
            end
            if (last_col) begin
               j_in  = '0;
               cc_in = {1'b0, col_ff};
               i_in  = i_ff + WIN_REG_W'(1);
               rr_in = rr_next;
               if (last_row) begin
                  state_in = S_SUM_TAIL;
               end
            end else begin
               j_in  = j_ff + WIN_REG_W'(1);
               cc_in = cc_next;
            end
         end
         S_SUM_TAIL: begin
            rsp_valid_in  = 1'b1;
            rsp_sum_in    = alu_res[31:0];
            rsp_status_in = (ovf_ff | alu_sat) ? ST_SAT : ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      value_ff      <= value_in;
      delta_ff      <= delta_in;
      rr_ff         <= rr_in;
      cc_ff         <= cc_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      acc_ff        <= acc_in;
      ovf_ff        <= ovf_in;
      pend_ff       <= pend_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = rsp_sum_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
